/* rtl/lkvc_pkg.sv */
// Package: types, constants and state codes for the LRU key/value cache.
`timescale 1ns / 1ps
package lkvc_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int AgeW = IdxW;
  localparam int CntW = IdxW + 1;
  localparam int DataW = 32;
  localparam logic [DataW-1:0] MissValue = '1;
  localparam logic FuncGet = 1'b0;
  localparam logic FuncSet = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic result_set;
    logic result_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_set;
    logic result_full;
  } ctrl_status_t;
endpackage

/* rtl/lkvc_ctrl.sv */
// Controller: sequences one transaction through lookup and result.
`timescale 1ns / 1ps
module lkvc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic                  out_fire,
  input  lkvc_pkg::ctrl_status_t status,
  output lkvc_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);
  import lkvc_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (status.is_set || !status.result_full || out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    cmd.result_clear = out_fire;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      ST_LOOKUP: begin
        cmd.update = status.is_set;
        cmd.result_set = !status.is_set && (!status.result_full || out_fire);
      end
      default: busy = 1'b1;
    endcase
  end
endmodule

/* rtl/lkvc_dpath.sv */
// Datapath: entry storage, parallel key match, age update, result register.
`timescale 1ns / 1ps
module lkvc_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [4:0]                  capacity,
  input  logic                        func,
  input  logic signed [31:0]          key,
  input  logic signed [31:0]          value,
  input  lkvc_pkg::ctrl_cmd_t          cmd,
  output lkvc_pkg::ctrl_status_t       status,
  output logic signed [31:0]          read_value,
  output logic                        hit,
  output logic                        valid
);
  import lkvc_pkg::*;
  logic             op_set;
  logic [DataW-1:0] op_key, op_val;
  logic [DataW-1:0] keys [Entries];
  logic [DataW-1:0] vals [Entries];
  logic [Entries-1:0] ev;
  logic [AgeW-1:0]  age [Entries];
  logic [CntW-1:0]  occ;
  logic [Entries-1:0] match;
  logic             found, full, use_free, have_slot;
  logic [IdxW-1:0]  mslot, oslot, fslot, slot;
  logic             fany;
  logic [CntW-1:0]  cap_eff, limit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_set <= (func == FuncSet);
      op_key <= key;
      op_val <= value;
    end
  end

  assign status.is_set = op_set;
  assign status.result_full = valid;

  always_comb begin
    mslot = '0; oslot = '0; fslot = '0; fany = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = ev[i] && (keys[i] == op_key);
      if (match[i]) mslot = IdxW'(i);
      if (ev[i] && age[i] == AgeW'(occ - CntW'(1))) oslot = IdxW'(i);
    end
    for (int i = Entries - 1; i >= 0; i--)
      if (!ev[i]) begin
        fslot = IdxW'(i);
        fany = 1'b1;
      end
  end

  assign found = |match;
  always_comb begin
    cap_eff = capacity;
    if (capacity == 5'd0) cap_eff = CntW'(1);
    if (capacity > 5'(Entries)) cap_eff = CntW'(Entries);
  end
  assign full = occ >= cap_eff;
  assign use_free = !found && !full;
  assign have_slot = found || (full ? (occ != '0) : fany);
  assign slot = found ? mslot : (full ? oslot : fslot);
  assign limit = found ? CntW'(age[mslot]) : (full ? occ - CntW'(1) : CntW'(Entries));

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
      occ <= '0;
      for (int i = 0; i < Entries; i++) age[i] <= '0;
    end else if (cmd.update && have_slot) begin
      for (int i = 0; i < Entries; i++)
        if (IdxW'(i) != slot && ev[i] && CntW'(age[i]) < limit)
          age[i] <= age[i] + AgeW'(1);
      age[slot] <= '0;
      if (use_free) begin
        ev[slot] <= 1'b1;
        occ <= occ + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && have_slot) begin
      keys[slot] <= op_key;
      vals[slot] <= op_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (cmd.result_set) valid <= 1'b1;
    else if (cmd.result_clear) valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.result_set) begin
      hit <= found;
      read_value <= found ? vals[mslot] : MissValue;
    end
  end
endmodule

/* rtl/lru_key_value_cache.sv */
// Top level: LRU key/value cache with valid/ready channels.
`timescale 1ns / 1ps
// Fully associative 16-entry LRU key/value store. One transaction at a time,
// each passing through the accept, then a lookup state in which all keys are
// compared in parallel and the entry or the result register is updated, so a
// new transaction is not accepted until the earlier lookup state ends. A get's
// result is registered at the end of its lookup and sits in an output register
// until taken; input keeps being accepted meanwhile, and only a following get
// stalls in its lookup state until the earlier result is taken. A set gives no result.
// Capacity may be written only while idle.
module lru_key_value_cache (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic               hit
);
  import lkvc_pkg::*;
  logic [4:0] capacity;
  ctrl_cmd_t cmd;
  ctrl_status_t status;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) capacity <= 5'd16;
    else if (cfg_we) capacity <= cfg_wdata;
  end

  assign in_ready = !busy;

  lkvc_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(in_valid && in_ready),
    .out_fire(out_valid && out_ready),
    .status, .cmd, .busy
  );

  lkvc_dpath u_dpath (
    .clk, .rst, .capacity, .func, .key, .value, .cmd, .status,
    .read_value, .hit, .valid(out_valid)
  );

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_value) && $stable(hit)))
    else $error("result dropped or changed while waiting");
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == -32'sd1)) else $error("miss value");
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("not busy after accept");
endmodule

/* tb/sv/lru_key_value_cache_test.sv */
// Testbench: random and directed get/set traffic against an LRU cache predictor.
`timescale 1ns / 1ps
module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic        is_cfg;
    logic [4:0]  cap;
    logic        op;
    logic [31:0] k;
    logic [31:0] v;
  } pend_t;

  typedef struct packed {
    logic [31:0] val;
    logic        hit;
  } lookup_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [4:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic func = 0;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] read_value;
  logic hit;

  lru_key_value_cache dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .key(key),
    .value(value), .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .hit(hit)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  logic [4:0]  cap_reg;
  logic [31:0] slot_key [Entries];
  logic [31:0] slot_val [Entries];
  logic        slot_vld [Entries];
  int unsigned slot_age [Entries];
  int unsigned fill;

  pend_t   pending[$];
  lookup_t lookups_due[$];
  int errors = 0;
  int gets_seen = 0;
  int hits_seen = 0;
  int sets_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  function automatic int unsigned eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > Entries) return Entries;
    return 32'(cap_reg);
  endfunction

  function automatic void make_newest(int s, int unsigned lim);
    for (int i = 0; i < Entries; i++)
      if (i != s && slot_vld[i] && slot_age[i] < lim) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void cache_apply(logic op, logic [31:0] k, logic [31:0] v);
    int s;
    int unsigned oldest;
    lookup_t r;
    s = -1;
    oldest = 0;
    for (int i = 0; i < Entries; i++)
      if (s < 0 && slot_vld[i] && slot_key[i] == k) s = i;
    if (op == FuncGet) begin
      r.val = (s >= 0) ? slot_val[s] : MissValue;
      r.hit = (s >= 0);
      lookups_due.insert(lookups_due.size(), r);
      return;
    end
    if (s >= 0) begin
      slot_val[s] = v;
      make_newest(s, slot_age[s]);
    end else if (fill >= eff_cap()) begin
      for (int i = 0; i < Entries; i++)
        if (slot_vld[i] && (s < 0 || slot_age[i] > oldest)) begin
          oldest = slot_age[i];
          s = i;
        end
      if (s < 0) return;
      slot_key[s] = k;
      slot_val[s] = v;
      make_newest(s, oldest);
    end else begin
      for (int i = Entries - 1; i >= 0; i--)
        if (!slot_vld[i]) s = i;
      if (s < 0) return;
      slot_vld[s] = 1;
      slot_key[s] = k;
      slot_val[s] = v;
      make_newest(s, 32'hFFFF_FFFF);
      fill++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      cfg_we <= 0;
    end else begin
      if (in_valid && in_ready) begin
        cache_apply(func, key, value);
        if (func == FuncSet) sets_sent++;
      end
      if (cfg_we) begin
        cfg_we <= 0;
      end else if (!(in_valid && !in_ready)) begin
        if (pending.size() > 0 && pending[0].is_cfg) begin
          in_valid <= 0;
          if (lookups_due.size() == 0 && !out_valid && !in_valid) begin
            cfg_we <= 1;
            cfg_wdata <= pending[0].cap;
            cap_reg = pending[0].cap;
            pending.delete(0);
          end
        end else if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1;
          func <= pending[0].op;
          key <= pending[0].k;
          value <= pending[0].v;
          pending.delete(0);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        gets_seen++;
        if (lookups_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result read_value=%h hit=%b", $time, read_value, hit);
        end else begin
          if (read_value !== lookups_due[0].val) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time,
                     lookups_due[0].val, read_value);
          end
          if (hit !== lookups_due[0].hit) begin
            errors++;
            $display("%0t: hit expected %b actual %b", $time, lookups_due[0].hit, hit);
          end
          if (hit) hits_seen++;
          lookups_due.delete(0);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: no progress, %0d results outstanding", $time, lookups_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rnd32();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic op, logic [31:0] k, logic [31:0] v);
    pend_t p;
    p = '0;
    p.op = op;
    p.k = k;
    p.v = v;
    pending.insert(pending.size(), p);
  endtask

  task automatic add_cap(logic [4:0] c);
    pend_t p;
    p = '0;
    p.is_cfg = 1;
    p.cap = c;
    pending.insert(pending.size(), p);
  endtask

  task automatic drain();
    while (pending.size() > 0 || lookups_due.size() > 0 || in_valid || cfg_we)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // random phase drawn from a small key pool so hits and evictions are common
  task automatic random_burst(int n);
    logic [31:0] pool [24];
    for (int i = 0; i < 24; i++) pool[i] = rnd32();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        add_item(1'($urandom_range(1)), rnd32(), rnd32());
      else
        add_item(1'($urandom_range(1)), pool[$urandom_range(23)], $urandom);
    end
  endtask

  initial begin
    cap_reg = 5'd16;
    fill = 0;
    for (int i = 0; i < Entries; i++) begin
      slot_vld[i] = 0;
      slot_age[i] = 0;
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: miss on empty, extremes, update, eviction at capacity 1 and 2
    add_item(FuncGet, 32'h0, 32'h0);
    add_item(FuncSet, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(FuncSet, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(FuncGet, 32'h8000_0000, 32'hFFFF_FFFF);
    add_item(FuncGet, 32'h7FFF_FFFF, 32'h0);
    add_item(FuncSet, 32'h8000_0000, 32'hFFFF_FFFF);
    add_item(FuncGet, 32'h8000_0000, 32'h0);
    add_item(FuncGet, 32'hFFFF_FFFF, 32'h0);
    add_cap(5'd0);
    add_item(FuncSet, 32'h1, 32'hA5A5_5A5A);
    add_item(FuncGet, 32'h1, 32'h0);
    add_item(FuncGet, 32'h7FFF_FFFF, 32'h0);
    add_item(FuncGet, 32'h8000_0000, 32'h0);
    add_cap(5'd31);
    for (int i = 0; i < 18; i++) add_item(FuncSet, i + 100, ~i);
    add_cap(5'd2);
    add_item(FuncSet, 32'd5, 32'd55);
    add_item(FuncGet, 32'd100, 32'd0);
    add_item(FuncGet, 32'd117, 32'd0);
    drain();

    send_idle = 0;  recv_stall = 0;  add_cap(5'd1);  random_burst(200);
    drain();
    send_idle = 87; recv_stall = 0;  add_cap(5'd16); random_burst(200);
    drain();
    send_idle = 0;  recv_stall = 87; add_cap(5'd4);  random_burst(200);
    drain();
    send_idle = 19; recv_stall = 19; add_cap(5'd31); random_burst(200);
    drain();
    send_idle = 0;  recv_stall = 0;  add_cap(5'd8);  random_burst(200);
    drain();

    $display("Covered %0d sets and %0d gets (%0d hits) over capacities 0..31, four idle mixes.",
             sets_sent, gets_seen, hits_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* lru_key_value_cache.f */
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dpath.sv
rtl/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_test.sv
